FILE: rtl/core/i2cmt_pkg.sv
`default_nettype none

package i2cmt_pkg;

  localparam int unsigned TX_DEPTH_DEF = 16;
  localparam int unsigned RX_DEPTH_DEF = 16;
  localparam int unsigned ADDR_W       = 7;
  localparam int unsigned LEVEL_W      = 4;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_START  = 2'd2,
    OP_STATUS = 2'd3
  } op_t;

  localparam logic [7:0] CTL_CONTINUE = 8'hC5;
  localparam logic [7:0] CTL_STOP     = 8'hD5;
  localparam logic [7:0] CTL_NACK     = 8'h85;
  localparam logic [7:0] CTL_START    = 8'hE5;

  localparam logic [7:0] ST_START        = 8'h08;
  localparam logic [7:0] ST_ADDR_ACK     = 8'h18;
  localparam logic [7:0] ST_ADDR_NACK    = 8'h20;
  localparam logic [7:0] ST_DATA_ACK     = 8'h28;
  localparam logic [7:0] ST_DATA_NACK    = 8'h30;
  localparam logic [7:0] ST_ARB_LOST     = 8'h38;
  localparam logic [7:0] ST_SLA_W        = 8'h60;
  localparam logic [7:0] ST_ARB_SLA_W    = 8'h70;
  localparam logic [7:0] ST_SR_DATA_ACK  = 8'h80;
  localparam logic [7:0] ST_SR_DATA_NACK = 8'h88;
  localparam logic [7:0] ST_GC_DATA_ACK  = 8'h90;
  localparam logic [7:0] ST_GC_DATA_NACK = 8'h98;

  typedef struct packed {
    op_t        operation;
    logic [7:0] tx_byte;
    logic [7:0] status_code;
    logic [7:0] bus_data;
    logic       stop_pending;
  } in_item_t;

  typedef struct packed {
    logic               control_valid;
    logic [7:0]         control_byte;
    logic               data_valid;
    logic [7:0]         data_byte;
    logic [7:0]         popped_byte;
    logic               busy_res;
    logic [LEVEL_W-1:0] tx_level;
    logic [LEVEL_W-1:0] rx_level;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic pop_one;
    logic pop_two;
  } ring_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/i2cmt_if.sv
`default_nettype none

interface i2cmt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] tx_byte;
  logic [7:0] status_code;
  logic [7:0] bus_data;
  logic       stop_pending;

  modport source (output valid, operation, tx_byte, status_code, bus_data, stop_pending,
                  input ready);
  modport sink   (input valid, operation, tx_byte, status_code, bus_data, stop_pending,
                  output ready);
endinterface

interface i2cmt_out_if;
  logic                              valid;
  logic                              ready;
  logic                              control_valid;
  logic [7:0]                        control_byte;
  logic                              data_valid;
  logic [7:0]                        data_byte;
  logic [7:0]                        popped_byte;
  logic                              busy_res;
  logic [i2cmt_pkg::LEVEL_W-1:0]     tx_level;
  logic [i2cmt_pkg::LEVEL_W-1:0]     rx_level;

  modport source (output valid, control_valid, control_byte, data_valid, data_byte,
                  popped_byte, busy_res, tx_level, rx_level,
                  input ready);
  modport sink   (input valid, control_valid, control_byte, data_valid, data_byte,
                  popped_byte, busy_res, tx_level, rx_level,
                  output ready);
endinterface

interface i2cmt_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [i2cmt_pkg::ADDR_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/i2c_master_tx_slave_rx_engine.sv
// Two-wire bus engine: master transmitter with a slave receiver.
// in_ch carries one command beat: push a transmit byte, pop a received byte,
// request a start, or hand over a controller status code with its data byte.
// out_ch returns exactly one result beat per command: control and data bytes
// to write to the controller, the popped byte, the busy flag and both ring
// levels after the command. cfg_ch writes the seven-bit target address; it
// is always ready. The user must see it is written only while the engine is
// idle; the engine does not enforce this. Throughput: one beat per cycle
// while out_ch does not stall; each beat updates the ring pointers and the
// busy flag once, in the single processing stage between the input register
// and the result register. Ring entries sit in RAMs read at the next tail
// pointer, with a forward path for a same-cycle write.
// Reset clears both ring pointers, the busy flag, the target address and
// both pipeline valids; ring contents stay undefined and need no clearing.
// When out_ch stalls the result register holds, the processing stage holds
// its beat, and if it has one, in_ch.ready drops until the result is taken.
`default_nettype none

module i2c_master_tx_slave_rx_engine #(
  parameter int unsigned TX_DEPTH = i2cmt_pkg::TX_DEPTH_DEF,
  parameter int unsigned RX_DEPTH = i2cmt_pkg::RX_DEPTH_DEF
) (
  input wire logic     clk,
  input wire logic     rst_n,
  i2cmt_in_if.sink     in_ch,
  i2cmt_out_if.source  out_ch,
  i2cmt_cfg_if.sink    cfg_ch
);

  localparam int unsigned TX_PW = $clog2(TX_DEPTH);
  localparam int unsigned RX_PW = $clog2(RX_DEPTH);

  logic [i2cmt_pkg::ADDR_W-1:0] addr_r;

  logic                  s1_valid_r, s1_valid_nxt;
  i2cmt_pkg::in_item_t   s1_r;
  logic                  out_valid_r, out_valid_nxt;
  i2cmt_pkg::out_item_t  out_r, res;
  logic                  busy_r, busy_nxt;
  logic                  adv, go;

  i2cmt_pkg::ring_ctl_t  tx_ctl, rx_ctl;
  logic [7:0]            tx_rd, rx_rd;
  logic [TX_PW-1:0]      tx_lvl, tx_lvl_nxt;
  logic [RX_PW-1:0]      rx_lvl, rx_lvl_nxt;

  assign cfg_ch.ready = 1'b1;
  assign adv          = !out_valid_r || out_ch.ready;
  assign go           = s1_valid_r && adv;
  assign in_ch.ready  = !s1_valid_r || adv;

  always_comb begin
    res      = '0;
    tx_ctl   = '0;
    rx_ctl   = '0;
    busy_nxt = busy_r;
    case (s1_r.operation)
      i2cmt_pkg::OP_PUSH: begin
        tx_ctl.push = 1'b1;
      end
      i2cmt_pkg::OP_POP: begin
        rx_ctl.pop_one  = 1'b1;
        res.popped_byte = rx_rd;
      end
      i2cmt_pkg::OP_START: begin
        if (!busy_r && !s1_r.stop_pending) begin
          busy_nxt          = 1'b1;
          res.control_valid = 1'b1;
          res.control_byte  = i2cmt_pkg::CTL_START;
        end
      end
      i2cmt_pkg::OP_STATUS: begin
        res.control_valid = 1'b1;
        case (s1_r.status_code)
          i2cmt_pkg::ST_START: begin
            res.data_valid   = 1'b1;
            res.data_byte    = {addr_r, 1'b0};
            res.control_byte = i2cmt_pkg::CTL_CONTINUE;
          end
          i2cmt_pkg::ST_ADDR_ACK, i2cmt_pkg::ST_DATA_ACK: begin
            if (tx_lvl != '0) begin
              tx_ctl.pop_one   = 1'b1;
              res.data_valid   = 1'b1;
              res.data_byte    = tx_rd;
              res.control_byte = i2cmt_pkg::CTL_CONTINUE;
            end else begin
              busy_nxt         = 1'b0;
              res.control_byte = i2cmt_pkg::CTL_STOP;
            end
          end
          i2cmt_pkg::ST_ADDR_NACK: begin
            if (tx_lvl > TX_PW'(1)) begin
              tx_ctl.pop_one = tx_lvl[0];
              tx_ctl.pop_two = !tx_lvl[0];
            end
            busy_nxt         = 1'b0;
            res.control_byte = i2cmt_pkg::CTL_STOP;
          end
          i2cmt_pkg::ST_DATA_NACK: begin
            tx_ctl.pop_one   = tx_lvl[0];
            busy_nxt         = 1'b0;
            res.control_byte = i2cmt_pkg::CTL_STOP;
          end
          i2cmt_pkg::ST_ARB_LOST: begin
            busy_nxt         = 1'b0;
            res.control_byte = i2cmt_pkg::CTL_CONTINUE;
          end
          i2cmt_pkg::ST_SLA_W, i2cmt_pkg::ST_ARB_SLA_W: begin
            res.control_byte = i2cmt_pkg::CTL_CONTINUE;
          end
          i2cmt_pkg::ST_SR_DATA_ACK, i2cmt_pkg::ST_GC_DATA_ACK: begin
            rx_ctl.push      = 1'b1;
            res.control_byte = i2cmt_pkg::CTL_NACK;
          end
          i2cmt_pkg::ST_SR_DATA_NACK, i2cmt_pkg::ST_GC_DATA_NACK: begin
            rx_ctl.push      = 1'b1;
            res.control_byte = i2cmt_pkg::CTL_CONTINUE;
          end
          default: begin
            busy_nxt         = 1'b0;
            res.control_byte = i2cmt_pkg::CTL_STOP;
          end
        endcase
      end
      default: begin
      end
    endcase
    if (!go) begin
      tx_ctl   = '0;
      rx_ctl   = '0;
      busy_nxt = busy_r;
    end
    res.busy_res = busy_nxt;
    res.tx_level = i2cmt_pkg::LEVEL_W'(tx_lvl_nxt);
    res.rx_level = i2cmt_pkg::LEVEL_W'(rx_lvl_nxt);
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ch.ready) begin
      s1_valid_nxt = in_ch.valid;
    end
    out_valid_nxt = out_valid_r;
    if (go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      busy_r      <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        addr_r <= cfg_ch.data;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      busy_r      <= busy_nxt;
    end
    if (in_ch.valid && in_ch.ready) begin
      s1_r.operation    <= i2cmt_pkg::op_t'(in_ch.operation);
      s1_r.tx_byte      <= in_ch.tx_byte;
      s1_r.status_code  <= in_ch.status_code;
      s1_r.bus_data     <= in_ch.bus_data;
      s1_r.stop_pending <= in_ch.stop_pending;
    end
    if (go) begin
      out_r <= res;
    end
  end

  i2cmt_ring #(
    .DEPTH (TX_DEPTH)
  ) u_tx_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (tx_ctl),
    .wdata     (s1_r.tx_byte),
    .rd_data   (tx_rd),
    .level     (tx_lvl),
    .level_nxt (tx_lvl_nxt)
  );

  i2cmt_ring #(
    .DEPTH (RX_DEPTH)
  ) u_rx_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (rx_ctl),
    .wdata     (s1_r.bus_data),
    .rd_data   (rx_rd),
    .level     (rx_lvl),
    .level_nxt (rx_lvl_nxt)
  );

  assign out_ch.valid         = out_valid_r;
  assign out_ch.control_valid = out_r.control_valid;
  assign out_ch.control_byte  = out_r.control_byte;
  assign out_ch.data_valid    = out_r.data_valid;
  assign out_ch.data_byte     = out_r.data_byte;
  assign out_ch.popped_byte   = out_r.popped_byte;
  assign out_ch.busy_res      = out_r.busy_res;
  assign out_ch.tx_level      = out_r.tx_level;
  assign out_ch.rx_level      = out_r.rx_level;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !go)
    else $error("result register overwritten while stalled");

  a_data_has_ctl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.data_valid |-> out_r.control_valid)
    else $error("data write without control write");

  a_start_refused: assert property (@(posedge clk) disable iff (!rst_n)
    go && (s1_r.operation == i2cmt_pkg::OP_START) && busy_r |=> !out_r.control_valid)
    else $error("start granted while busy");

  a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> $past(go) && ($past(s1_r.operation) == i2cmt_pkg::OP_START))
    else $error("busy set without a start request");

  a_busy_reported: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> out_r.busy_res == busy_r)
    else $error("reported busy flag differs from state");

  a_rx_level_on_push: assert property (@(posedge clk) disable iff (!rst_n)
    go && (s1_r.operation == i2cmt_pkg::OP_PUSH) |=>
      out_r.rx_level == i2cmt_pkg::LEVEL_W'($past(rx_lvl)))
    else $error("receive level moved on a transmit push");

endmodule

`default_nettype wire

FILE: rtl/core/i2cmt_ram.sv
`default_nettype none

module i2cmt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/i2cmt_ring.sv
`default_nettype none

module i2cmt_ring #(
  parameter int unsigned DEPTH = i2cmt_pkg::TX_DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire i2cmt_pkg::ring_ctl_t     ctl,
  input  wire logic [7:0]               wdata,
  output logic      [7:0]               rd_data,
  output logic      [$clog2(DEPTH)-1:0] level,
  output logic      [$clog2(DEPTH)-1:0] level_nxt
);

  localparam int unsigned PW = $clog2(DEPTH);

  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic [PW-1:0] tail_one, tail_two;
  logic          byp_r, byp_nxt;
  logic [7:0]    byp_data_r;
  logic [7:0]    ram_q;

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] idx);
    return (idx == PW'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [PW-1:0] ring_level(input logic [PW-1:0] h,
                                               input logic [PW-1:0] t);
    logic [PW:0] diff;
    diff = {1'b0, h} - {1'b0, t};
    return diff[PW] ? diff[PW-1:0] + PW'(DEPTH) : diff[PW-1:0];
  endfunction

  always_comb begin
    tail_one = ptr_next(tail_r);
    tail_two = ptr_next(tail_one);
    head_nxt = ctl.push ? ptr_next(head_r) : head_r;
    if (ctl.pop_two) begin
      tail_nxt = tail_two;
    end else if (ctl.pop_one) begin
      tail_nxt = tail_one;
    end else begin
      tail_nxt = tail_r;
    end
    byp_nxt   = ctl.push && (head_r == tail_nxt);
    level     = ring_level(head_r, tail_r);
    level_nxt = ring_level(head_nxt, tail_nxt);
    rd_data   = byp_r ? byp_data_r : ram_q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      byp_r  <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      byp_r  <= byp_nxt;
    end
    byp_data_r <= wdata;
  end

  i2cmt_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.push),
    .waddr (head_r),
    .wdata (wdata),
    .raddr (tail_nxt),
    .rdata (ram_q)
  );

endmodule

`default_nettype wire

FILE: verif/i2cmt_checker.sv
`default_nettype none

module i2cmt_checker (
  input  wire logic   clk,
  input  wire logic   rst_n,
  i2cmt_in_if         in_ch,
  i2cmt_out_if        out_ch,
  i2cmt_cfg_if        cfg_ch,
  output int unsigned fail_count,
  output int unsigned pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import i2cmt_pkg::*;

  logic [7:0]         tx_mem [TX_DEPTH_DEF];
  logic [7:0]         rx_mem [RX_DEPTH_DEF];
  logic [LEVEL_W-1:0] tx_wr, tx_rd, rx_wr, rx_rd;
  logic               master_busy;
  logic [ADDR_W-1:0]  target_addr;
  out_item_t          expected_q [$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  function automatic out_item_t predict_result(in_item_t cmd);
    out_item_t          r;
    logic [LEVEL_W-1:0] lvl;
    r   = '0;
    lvl = tx_wr - tx_rd;
    case (cmd.operation)
      OP_PUSH: begin
        tx_mem[tx_wr] = cmd.tx_byte;
        tx_wr         = tx_wr + 1'b1;
      end
      OP_POP: begin
        r.popped_byte = rx_mem[rx_rd];
        rx_rd         = rx_rd + 1'b1;
      end
      OP_START: begin
        if (!master_busy && !cmd.stop_pending) begin
          master_busy     = 1'b1;
          r.control_valid = 1'b1;
          r.control_byte  = CTL_START;
        end
      end
      default: begin
        r.control_valid = 1'b1;
        case (cmd.status_code)
          ST_START: begin
            r.data_valid   = 1'b1;
            r.data_byte    = {target_addr, 1'b0};
            r.control_byte = CTL_CONTINUE;
          end
          ST_ADDR_ACK, ST_DATA_ACK: begin
            if (lvl != 0) begin
              r.data_valid   = 1'b1;
              r.data_byte    = tx_mem[tx_rd];
              tx_rd          = tx_rd + 1'b1;
              r.control_byte = CTL_CONTINUE;
            end else begin
              master_busy    = 1'b0;
              r.control_byte = CTL_STOP;
            end
          end
          ST_ADDR_NACK: begin
            // with two or more queued, drop one or two entries so an even count is left
            if (lvl >= 2) tx_rd = tx_rd + (lvl[0] ? 4'd1 : 4'd2);
            master_busy    = 1'b0;
            r.control_byte = CTL_STOP;
          end
          ST_DATA_NACK: begin
            if (lvl[0]) tx_rd = tx_rd + 1'b1;
            master_busy    = 1'b0;
            r.control_byte = CTL_STOP;
          end
          ST_ARB_LOST: begin
            master_busy    = 1'b0;
            r.control_byte = CTL_CONTINUE;
          end
          ST_SLA_W, ST_ARB_SLA_W: begin
            r.control_byte = CTL_CONTINUE;
          end
          ST_SR_DATA_ACK, ST_GC_DATA_ACK: begin
            rx_mem[rx_wr]  = cmd.bus_data;
            rx_wr          = rx_wr + 1'b1;
            r.control_byte = CTL_NACK;
          end
          ST_SR_DATA_NACK, ST_GC_DATA_NACK: begin
            rx_mem[rx_wr]  = cmd.bus_data;
            rx_wr          = rx_wr + 1'b1;
            r.control_byte = CTL_CONTINUE;
          end
          default: begin
            master_busy    = 1'b0;
            r.control_byte = CTL_STOP;
          end
        endcase
      end
    endcase
    r.busy_res = master_busy;
    r.tx_level = tx_wr - tx_rd;
    r.rx_level = rx_wr - rx_rd;
    return r;
  endfunction

  function automatic bit field_mismatch(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin : monitor
    out_item_t   got;
    out_item_t   want;
    in_item_t    cmd;
    bit          bad;
    int unsigned errs;
    errs = 0;
    if (!rst_n) begin
      tx_wr       = '0;
      tx_rd       = '0;
      rx_wr       = '0;
      rx_rd       = '0;
      master_busy = 1'b0;
      target_addr = '0;
      expected_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.control_valid = out_ch.control_valid;
        got.control_byte  = out_ch.control_byte;
        got.data_valid    = out_ch.data_valid;
        got.data_byte     = out_ch.data_byte;
        got.popped_byte   = out_ch.popped_byte;
        got.busy_res      = out_ch.busy_res;
        got.tx_level      = out_ch.tx_level;
        got.rx_level      = out_ch.rx_level;
        if (expected_q.size() == 0) begin
          $display("%0t ns: unexpected result beat, expected none, actual %h", $time, got);
          errs++;
        end else begin
          want = expected_q.pop_front();
          bad  = 1'b0;
          bad |= field_mismatch("control_valid", 8'(want.control_valid),
                                8'(got.control_valid));
          bad |= field_mismatch("control_byte", want.control_byte, got.control_byte);
          bad |= field_mismatch("data_valid", 8'(want.data_valid), 8'(got.data_valid));
          bad |= field_mismatch("data_byte", want.data_byte, got.data_byte);
          bad |= field_mismatch("popped_byte", want.popped_byte, got.popped_byte);
          bad |= field_mismatch("busy_res", 8'(want.busy_res), 8'(got.busy_res));
          bad |= field_mismatch("tx_level", 8'(want.tx_level), 8'(got.tx_level));
          bad |= field_mismatch("rx_level", 8'(want.rx_level), 8'(got.rx_level));
          if (bad) errs++;
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) target_addr = cfg_ch.data;
      if (in_ch.valid && in_ch.ready) begin
        cmd.operation    = op_t'(in_ch.operation);
        cmd.tx_byte      = in_ch.tx_byte;
        cmd.status_code  = in_ch.status_code;
        cmd.bus_data     = in_ch.bus_data;
        cmd.stop_pending = in_ch.stop_pending;
        expected_q.push_back(predict_result(cmd));
      end
    end
    fail_count    <= fail_count + errs;
    pending_count <= expected_q.size();
  end

endmodule

`default_nettype wire

FILE: verif/tb_i2c_master_tx_slave_rx_engine.sv
`default_nettype none

module tb_i2c_master_tx_slave_rx_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cmt_pkg::*;

  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned PHASE_BEATS = 170;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned beats_sent;
  int unsigned quiet_cycles;
  logic [3:0]  rx_wr_ptr;
  logic [3:0]  rx_rd_ptr;
  logic [15:0] rx_filled;

  i2cmt_in_if  in_ch ();
  i2cmt_out_if out_ch ();
  i2cmt_cfg_if cfg_ch ();

  i2c_master_tx_slave_rx_engine i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  i2cmt_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= IDLE_LIMIT) begin
        $display("i2c_master_tx_slave_rx_engine regression: fail");
        $finish;
      end
    end
  end

  function automatic logic [7:0] pick_status_code();
    if ($urandom_range(1) == 0) return 8'($urandom_range(255));
    case ($urandom_range(11))
      0:       return ST_START;
      1:       return ST_ADDR_ACK;
      2:       return ST_ADDR_NACK;
      3:       return ST_DATA_ACK;
      4:       return ST_DATA_NACK;
      5:       return ST_ARB_LOST;
      6:       return ST_SLA_W;
      7:       return ST_ARB_SLA_W;
      8:       return ST_SR_DATA_ACK;
      9:       return ST_SR_DATA_NACK;
      10:      return ST_GC_DATA_ACK;
      default: return ST_GC_DATA_NACK;
    endcase
  endfunction

  function automatic logic [7:0] pick_rx_code();
    case ($urandom_range(3))
      0:       return ST_SR_DATA_ACK;
      1:       return ST_SR_DATA_NACK;
      2:       return ST_GC_DATA_ACK;
      default: return ST_GC_DATA_NACK;
    endcase
  endfunction

  function automatic in_item_t make_item(op_t op);
    in_item_t it;
    it.operation    = op;
    it.tx_byte      = 8'($urandom_range(255));
    it.status_code  = 8'($urandom_range(255));
    it.bus_data     = 8'($urandom_range(255));
    it.stop_pending = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic bit is_rx_code(logic [7:0] code);
    return code == ST_SR_DATA_ACK || code == ST_SR_DATA_NACK ||
           code == ST_GC_DATA_ACK || code == ST_GC_DATA_NACK;
  endfunction

  // skip a pop whose ring entry was never written
  task automatic send_item(in_item_t it);
    if (it.operation == OP_POP && !rx_filled[rx_rd_ptr]) return;
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= it.operation;
    in_ch.tx_byte      <= it.tx_byte;
    in_ch.status_code  <= it.status_code;
    in_ch.bus_data     <= it.bus_data;
    in_ch.stop_pending <= it.stop_pending;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (it.operation == OP_STATUS && is_rx_code(it.status_code)) begin
      rx_filled[rx_wr_ptr] = 1'b1;
      rx_wr_ptr            = rx_wr_ptr + 1'b1;
    end
    if (it.operation == OP_POP) rx_rd_ptr = rx_rd_ptr + 1'b1;
    beats_sent++;
  endtask

  task automatic send_status(logic [7:0] code);
    in_item_t it;
    it             = make_item(OP_STATUS);
    it.status_code = code;
    send_item(it);
  endtask

  task automatic push_byte(logic [7:0] b);
    in_item_t it;
    it         = make_item(OP_PUSH);
    it.tx_byte = b;
    send_item(it);
  endtask

  task automatic pop_byte();
    send_item(make_item(OP_POP));
  endtask

  task automatic request_start(logic sp);
    in_item_t it;
    it              = make_item(OP_START);
    it.stop_pending = sp;
    send_item(it);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic write_target(logic [ADDR_W-1:0] addr);
    wait_drained();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= addr;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_sequence();
    int unsigned kind;
    int unsigned n;
    in_item_t    it;
    kind = $urandom_range(99);
    if (kind < 50) begin
      request_start($urandom_range(9) == 0);
      n = $urandom_range(5);
      repeat (n) push_byte(8'($urandom_range(255)));
      send_status(ST_START);
      if ($urandom_range(9) == 0) begin
        send_status(ST_ADDR_NACK);
      end else if ($urandom_range(19) == 0) begin
        send_status(ST_ARB_LOST);
      end else begin
        send_status(ST_ADDR_ACK);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(9) == 0) begin
            send_status(ST_DATA_NACK);
            break;
          end
          send_status(ST_DATA_ACK);
        end
      end
    end else if (kind < 75) begin
      send_status($urandom_range(1) ? ST_SLA_W : ST_ARB_SLA_W);
      send_status(pick_rx_code());
      send_status(pick_rx_code());
      repeat ($urandom_range(3)) pop_byte();
    end else if (kind < 85) begin
      repeat ($urandom_range(20, 14)) push_byte(8'($urandom_range(255)));
      repeat ($urandom_range(20)) send_status(ST_DATA_ACK);
    end else begin
      repeat ($urandom_range(4, 1)) begin
        it             = make_item(op_t'($urandom_range(3)));
        it.status_code = pick_status_code();
        send_item(it);
      end
    end
  endtask

  task automatic run_directed();
    in_item_t it;
    request_start(1'b1);
    request_start(1'b0);
    request_start(1'b0);
    send_status(ST_START);
    push_byte(8'h00);
    push_byte(8'hFF);
    send_status(ST_ADDR_ACK);
    send_status(ST_DATA_ACK);
    send_status(ST_DATA_ACK);
    repeat (3) push_byte(8'($urandom_range(255)));
    send_status(ST_ADDR_NACK);
    send_status(ST_ADDR_NACK);
    push_byte(8'($urandom_range(255)));
    send_status(ST_DATA_NACK);
    send_status(ST_DATA_NACK);
    send_status(ST_ARB_LOST);
    send_status(ST_SLA_W);
    send_status(ST_ARB_SLA_W);
    it             = make_item(OP_STATUS);
    it.status_code = ST_SR_DATA_ACK;
    it.bus_data    = 8'hFF;
    send_item(it);
    it.status_code = ST_GC_DATA_ACK;
    it.bus_data    = 8'h00;
    send_item(it);
    send_status(ST_SR_DATA_NACK);
    send_status(ST_GC_DATA_NACK);
    pop_byte();
    pop_byte();
    send_status(8'h00);
  endtask

  initial begin
    int unsigned target;
    rst_n              = 1'b0;
    src_idle_pct       = 0;
    sink_stall_pct     = 0;
    beats_sent         = 0;
    quiet_cycles       = 0;
    rx_wr_ptr          = '0;
    rx_rd_ptr          = '0;
    rx_filled          = '0;
    in_ch.valid        = 1'b0;
    in_ch.operation    = '0;
    in_ch.tx_byte      = '0;
    in_ch.status_code  = '0;
    in_ch.bus_data     = '0;
    in_ch.stop_pending = 1'b0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.data        = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_target(7'h7F);
    run_directed();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       write_target(7'h00);
        2:       write_target(7'h7F);
        default: write_target(7'($urandom_range(127)));
      endcase
      case (ph % 4)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 52; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 52; end
        default: begin src_idle_pct = 24; sink_stall_pct = 24; end
      endcase
      target = beats_sent + PHASE_BEATS;
      while (beats_sent < target) run_sequence();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("i2c_master_tx_slave_rx_engine regression: pass");
    end else begin
      $display("i2c_master_tx_slave_rx_engine regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
